// File: design/assert_macros.svh
// Concurrent assertion helpers for the RTL.
// Each macro samples on the rising edge of clk_i and is idle while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a sampled edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/cvl_pkg.sv
package cvl_pkg;

  // List geometry.
  localparam int Depth = 16;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  // Field widths that the interface fixes.
  localparam int DataW = 32;
  localparam int PosW  = 5;
  localparam int CapW  = 5;
  localparam int OutCntW = 5;

  // Configuration register map (register index taken from paddr[2]).
  localparam logic RegCapacity = 1'b0;
  localparam logic [CapW-1:0] CapacityReset = CapW'(16);

  typedef logic [DataW-1:0] word_t;

  // Command codes.
  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpFind   = 2'd2,
    OpGet    = 2'd3
  } op_e;

  // One command word.
  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
  } req_t;

  // One result word.
  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] read_data;
    logic [OutCntW-1:0]      count;
  } rsp_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic            ins_en;
    logic            rem_en;
    word_t           value;
    logic [CntW-1:0] fill;
    logic [IdxW-1:0] rd_idx;
  } cell_ctl_t;

endpackage

// File: design/cvl_cell.sv
module cvl_cell import cvl_pkg::*; (
  input  logic            clk_i,
  input  logic [IdxW-1:0] idx_i,
  input  cell_ctl_t       ctl_i,
  input  logic            hit_i,
  output logic            hit_o,
  input  word_t           next_i,
  output word_t           entry_o,
  input  word_t           rdata_i,
  output word_t           rdata_o
);

  word_t entry_q;
  logic  valid;
  logic  match;

  // The entry counts only below the fill level.
  assign valid = CntW'(idx_i) < ctl_i.fill;
  assign match = valid && (entry_q == ctl_i.value);

  // A hit at this cell or any lower one marks the first match and everything above it.
  assign hit_o = hit_i | match;

  // Append at the fill position, or take the upper neighbor's entry to close a gap.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins_en && (CntW'(idx_i) == ctl_i.fill)) begin
      entry_q <= ctl_i.value;
    end else if (ctl_i.rem_en && hit_o) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

  // Read chain: the addressed cell drops its entry onto the chain.
  assign rdata_o = (idx_i == ctl_i.rd_idx) ? entry_q : rdata_i;

endmodule

// File: design/compacting_value_list.sv
// Ordered list of signed 32-bit values, held in a row of cells.
// Commands come in on req_i and are taken at a rising edge where start is
// high and busy is low; busy stays low, so a command may be issued in every
// cycle. The four commands are insert (append if below capacity and depth),
// remove (delete the first equal entry and close the gap), find and get
// (1-based). Each command gives one result word on rsp_o, marked by done_o
// in the cycle after the command is taken: ok, read_data (nonzero only for
// a good get) and the count after the command. One command per cycle:
// every cell compares and shifts its own entry in the same cycle, and the
// first-match flag and the read data ripple once along the row of cells.
// The result is shown for exactly one cycle and the receiver cannot stall it.
// The capacity register lies at APB address 0; pready is always high.
// Reset empties the list and sets the capacity to 16; the stored values
// themselves are not cleared and need no clearing pass.
module compacting_value_list import cvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CapW-1:0] capacity_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic            done_q;
  rsp_t            rsp_q, rsp_d;

  logic            accept;
  logic            room;
  logic            pos_ok;
  logic            found;
  cell_ctl_t       ctl;

  logic  hit_chain   [Depth+1];
  word_t rdata_chain [Depth+1];
  word_t entry_w     [Depth];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegCapacity)) begin
      capacity_q <= pwdata[CapW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegCapacity) ? 32'(capacity_q) : 32'd0;

  // Room check against the smaller of capacity and depth.
  assign room   = (32'(fill_q) < 32'(capacity_q)) && (32'(fill_q) < 32'(Depth));
  assign pos_ok = (req_i.position != '0) && (32'(req_i.position) <= 32'(fill_q))
                  && (32'(req_i.position) <= 32'(Depth));

  // Broadcast word to the cells.
  always_comb begin
    ctl        = '0;
    ctl.ins_en = accept && (req_i.op == OpInsert) && room;
    ctl.rem_en = accept && (req_i.op == OpRemove);
    ctl.value  = word_t'(req_i.value);
    ctl.fill   = fill_q;
    ctl.rd_idx = IdxW'(32'(req_i.position) - 32'd1);
  end

  assign hit_chain[0]   = 1'b0;
  assign rdata_chain[0] = '0;

  // Row of cells, lowest position first.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    word_t next_w;
    if (i == Depth - 1) begin : g_last
      assign next_w = entry_w[i];
    end else begin : g_mid
      assign next_w = entry_w[i+1];
    end

    cvl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IdxW'(i)),
      .ctl_i   (ctl),
      .hit_i   (hit_chain[i]),
      .hit_o   (hit_chain[i+1]),
      .next_i  (next_w),
      .entry_o (entry_w[i]),
      .rdata_i (rdata_chain[i]),
      .rdata_o (rdata_chain[i+1])
    );
  end

  assign found = hit_chain[Depth];

  // Result and next fill level.
  always_comb begin
    fill_d        = fill_q;
    rsp_d.ok      = 1'b0;
    rsp_d.read_data = '0;
    case (req_i.op)
      OpInsert: begin
        if (room) begin
          fill_d   = fill_q + CntW'(1);
          rsp_d.ok = 1'b1;
        end
      end
      OpRemove: begin
        if (found) begin
          fill_d   = fill_q - CntW'(1);
          rsp_d.ok = 1'b1;
        end
      end
      OpFind: begin
        rsp_d.ok = found;
      end
      OpGet: begin
        if (pos_ok) begin
          rsp_d.ok        = 1'b1;
          rsp_d.read_data = rdata_chain[Depth];
        end
      end
      default: begin
        rsp_d.ok = 1'b0;
      end
    endcase
    rsp_d.count = OutCntW'(fill_d);
  end

  // Fill level and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Checks on the list bookkeeping.
  `include "assert_macros.svh"

  `ASSERT_CLK(a_done_follows_cmd, accept |=> done_o, "result strobe missing after command")
  `ASSERT_NEVER(a_fill_bound, 32'(fill_q) > 32'(Depth), "fill level above depth")
  `ASSERT_CLK(a_remove_shrinks,
              (ctl.rem_en && found) |=> (fill_q == $past(fill_q) - CntW'(1)),
              "remove did not shrink list")
  `ASSERT_CLK(a_hit_needs_fill, found |-> (fill_q != '0), "match reported in empty list")

endmodule
